/* sv/bphr_pkg.sv */
// ----------------------------------------------------------------------------
// bphr_pkg
// Shared pin map, report codes and request records for the button pad to
// gamepad report block.
// ----------------------------------------------------------------------------
package bphr_pkg;

    localparam int PIN_W = 21;

    // Pin positions in the sampled pin word (active low).
    localparam int PIN_LEFT  = 0;
    localparam int PIN_DOWN  = 1;
    localparam int PIN_GUIDE = 2;
    localparam int PIN_RIGHT = 3;
    localparam int PIN_UP    = 6;
    localparam int PIN_B     = 7;
    localparam int PIN_X     = 8;
    localparam int PIN_Y     = 9;
    localparam int PIN_RT    = 10;
    localparam int PIN_START = 11;
    localparam int PIN_BACK  = 12;
    localparam int PIN_RB    = 13;
    localparam int PIN_LB    = 14;
    localparam int PIN_A     = 19;
    localparam int PIN_LT    = 20;

    localparam logic [PIN_W-1:0] MASK_DIR  = 21'h00004b;
    localparam logic [PIN_W-1:0] MASK_FACE = 21'h080380;
    localparam logic [PIN_W-1:0] MASK_USED = 21'h187fcf;
    localparam logic [PIN_W-1:0] PINS_IDLE = 21'h1fffff;

    // Turbo, guide hold and mode constants.
    localparam int              TURBO_BIT      = 4;
    localparam logic [11:0]     HOLD_MAX       = 12'hfff;
    localparam logic [11:0]     HOLD_THR_RESET = 12'd1000;
    localparam logic [1:0]      MODE_SEND      = 2'd2;

    // Report encodings.
    localparam logic [7:0] AXIS_NEG   = 8'h81;
    localparam logic [7:0] AXIS_POS   = 8'h7f;
    localparam logic [7:0] AXIS_ZERO  = 8'h00;
    localparam logic [7:0] MISC_RESET = 8'hf0;

    localparam logic [3:0] HAT_UP         = 4'd0;
    localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
    localparam logic [3:0] HAT_RIGHT      = 4'd2;
    localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
    localparam logic [3:0] HAT_DOWN       = 4'd4;
    localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
    localparam logic [3:0] HAT_LEFT       = 4'd6;
    localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
    localparam logic [3:0] HAT_CENTER     = 4'd15;

    // Request handed from the front end to the report builder.
    typedef struct packed {
        logic [PIN_W-1:0] chg;
        logic [PIN_W-1:0] cooked;
        logic [1:0]       mode;
        logic             mode_adv;
        logic [3:0]       led;
    } cmd_t;

    // One finished result item.
    typedef struct packed {
        logic [7:0] buttons;
        logic [7:0] misc;
        logic [7:0] x;
        logic [7:0] y;
        logic       send;
        logic [1:0] mode;
        logic       mode_adv;
        logic [3:0] led;
    } result_t;

endpackage

/* sv/bphr_front.sv */
// ----------------------------------------------------------------------------
// bphr_front
// Accepts pin samples, detects raw and cooked edges, applies turbo and runs
// the guide button logic (turbo toggles, hold timing, mode and LEDs).
// ----------------------------------------------------------------------------
module bphr_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [bphr_pkg::PIN_W-1:0]     raw_pins,
    input  logic                           cfg_valid,
    input  logic [11:0]                    cfg_data,
    output bphr_pkg::cmd_t                 cmd
);
    import bphr_pkg::*;

    logic [PIN_W-1:0] prev_raw_reg, prev_raw_next;
    logic [PIN_W-1:0] prev_cooked_reg, prev_cooked_next;
    logic [4:0]       turbo_cnt_reg, turbo_cnt_next;
    logic [3:0]       turbo_en_reg, turbo_en_next;
    logic [11:0]      hold_cnt_reg, hold_cnt_next;
    logic             hold_used_reg, hold_used_next;
    logic [1:0]       mode_reg, mode_next;
    logic [3:0]       led_reg, led_next;
    logic [11:0]      hold_thr_reg;

    logic [PIN_W-1:0] raw_chg;
    logic [PIN_W-1:0] raw_press;
    logic [PIN_W-1:0] raw_rel;
    logic [PIN_W-1:0] turbo_mask;
    logic [PIN_W-1:0] cooked;
    logic [PIN_W-1:0] chg;
    logic             mode_adv;

    // Edge detection and turbo masking.
    always_comb
    begin
        raw_chg   = (prev_raw_reg ^ raw_pins) & MASK_USED;
        raw_press = raw_chg & ~raw_pins;
        raw_rel   = raw_chg & raw_pins;

        turbo_mask = '0;
        if (turbo_cnt_reg[TURBO_BIT])
        begin
            turbo_mask[PIN_A] = turbo_en_reg[0];
            turbo_mask[PIN_B] = turbo_en_reg[1];
            turbo_mask[PIN_X] = turbo_en_reg[2];
            turbo_mask[PIN_Y] = turbo_en_reg[3];
        end
        cooked           = raw_pins | turbo_mask;
        chg              = (prev_cooked_reg ^ cooked) & MASK_USED;
        prev_raw_next    = raw_pins;
        prev_cooked_next = cooked;
        turbo_cnt_next   = turbo_cnt_reg + 5'd1;
    end

    // Guide button: turbo toggles while held, hold timing and mode change.
    always_comb
    begin
        turbo_en_next  = turbo_en_reg;
        hold_cnt_next  = hold_cnt_reg;
        hold_used_next = hold_used_reg;
        mode_next      = mode_reg;
        led_next       = led_reg;
        mode_adv       = 1'b0;

        if (hold_cnt_reg != '0)
        begin
            if (hold_cnt_reg < HOLD_MAX)
            begin
                hold_cnt_next = hold_cnt_reg + 12'd1;
            end
            turbo_en_next = turbo_en_reg ^ {raw_press[PIN_Y], raw_press[PIN_X],
                                            raw_press[PIN_B], raw_press[PIN_A]};
            if (((raw_press & (MASK_DIR | MASK_FACE)) != '0) || ((raw_rel & MASK_DIR) != '0))
            begin
                hold_used_next = 1'b1;
            end
            led_next = turbo_en_next;
        end

        if (chg[PIN_GUIDE])
        begin
            if (!cooked[PIN_GUIDE])
            begin
                hold_cnt_next = 12'd1;
            end
            else
            begin
                if (!hold_used_next && (hold_cnt_next > hold_thr_reg))
                begin
                    case (mode_reg)
                        2'd0:    mode_next = 2'd1;
                        2'd1:    mode_next = 2'd2;
                        2'd2:    mode_next = 2'd0;
                        default: mode_next = 2'd1;
                    endcase
                    mode_adv = 1'b1;
                end
                hold_cnt_next  = '0;
                hold_used_next = 1'b0;
                led_next       = 4'd1 << mode_next;
            end
        end
    end

    // Request to the report builder; face buttons read released under guide.
    always_comb
    begin
        cmd.chg      = chg;
        cmd.cooked   = cooked[PIN_GUIDE] ? cooked : (cooked | MASK_FACE);
        cmd.mode     = mode_next;
        cmd.mode_adv = mode_adv;
        cmd.led      = led_next;
    end

    // State registers, updated once per accepted sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg    <= PINS_IDLE;
            prev_cooked_reg <= PINS_IDLE;
            turbo_cnt_reg   <= '0;
            turbo_en_reg    <= '0;
            hold_cnt_reg    <= '0;
            hold_used_reg   <= 1'b0;
            mode_reg        <= '0;
            led_reg         <= 4'b0001;
        end
        else if (accept)
        begin
            prev_raw_reg    <= prev_raw_next;
            prev_cooked_reg <= prev_cooked_next;
            turbo_cnt_reg   <= turbo_cnt_next;
            turbo_en_reg    <= turbo_en_next;
            hold_cnt_reg    <= hold_cnt_next;
            hold_used_reg   <= hold_used_next;
            mode_reg        <= mode_next;
            led_reg         <= led_next;
        end
    end

    // Hold threshold configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_thr_reg <= HOLD_THR_RESET;
        end
        else if (cfg_valid)
        begin
            hold_thr_reg <= cfg_data;
        end
    end

endmodule

/* sv/bphr_cmd_queue.sv */
// ----------------------------------------------------------------------------
// bphr_cmd_queue
// Two-entry request queue between the front end and the report builder.
// ----------------------------------------------------------------------------
module bphr_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  bphr_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output logic           empty,
    output bphr_pkg::cmd_t rd_data
);
    import bphr_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/bphr_back.sv */
// ----------------------------------------------------------------------------
// bphr_back
// Report builder: applies each request to the stored 4-byte report and
// places the finished result in a two-entry output queue.
// ----------------------------------------------------------------------------
module bphr_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_empty,
    input  bphr_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    input  logic            pop,
    output logic            empty,
    output bphr_pkg::result_t res
);
    import bphr_pkg::*;

    logic [7:0] btn_reg, btn_next;
    logic [7:0] misc_reg, misc_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;

    result_t    out_mem [2];
    result_t    out_item;
    logic       out_wr_ptr_reg;
    logic       out_rd_ptr_reg;
    logic [1:0] out_count_reg, out_count_next;
    logic       out_pop;
    logic [3:0] hat;

    assign cmd_pop = !cmd_empty && (out_count_reg != 2'd2);
    assign empty   = (out_count_reg == 2'd0);
    assign out_pop = pop && !empty;
    assign res     = out_mem[out_rd_ptr_reg];

    // Report update from the changed bits of one request.
    always_comb
    begin
        btn_next  = btn_reg;
        misc_next = misc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        hat       = misc_reg[7:4];

        if (cmd.chg[PIN_A])     btn_next[0] = !cmd.cooked[PIN_A];
        if (cmd.chg[PIN_B])     btn_next[1] = !cmd.cooked[PIN_B];
        if (cmd.chg[PIN_X])     btn_next[2] = !cmd.cooked[PIN_X];
        if (cmd.chg[PIN_Y])     btn_next[3] = !cmd.cooked[PIN_Y];
        if (cmd.chg[PIN_LT])    btn_next[4] = !cmd.cooked[PIN_LT];
        if (cmd.chg[PIN_RT])    btn_next[5] = !cmd.cooked[PIN_RT];
        if (cmd.chg[PIN_LB])    btn_next[6] = !cmd.cooked[PIN_LB];
        if (cmd.chg[PIN_RB])    btn_next[7] = !cmd.cooked[PIN_RB];
        if (cmd.chg[PIN_START]) misc_next[0] = !cmd.cooked[PIN_START];
        if (cmd.chg[PIN_BACK])  misc_next[1] = !cmd.cooked[PIN_BACK];
        if (cmd.chg[PIN_GUIDE])
        begin
            misc_next[2] = !cmd.cooked[PIN_GUIDE];
            misc_next[3] = 1'b0;
        end

        // Left wins over right, up wins over down.
        if (cmd.chg[PIN_LEFT] || cmd.chg[PIN_RIGHT])
        begin
            if (!cmd.cooked[PIN_LEFT])       x_next = AXIS_NEG;
            else if (!cmd.cooked[PIN_RIGHT]) x_next = AXIS_POS;
            else                             x_next = AXIS_ZERO;
        end
        if (cmd.chg[PIN_UP] || cmd.chg[PIN_DOWN])
        begin
            if (!cmd.cooked[PIN_UP])         y_next = AXIS_NEG;
            else if (!cmd.cooked[PIN_DOWN])  y_next = AXIS_POS;
            else                             y_next = AXIS_ZERO;
        end

        // Hat code from the updated axes.
        if (cmd.chg != '0)
        begin
            if (x_next == AXIS_NEG)
            begin
                hat = (y_next == AXIS_NEG) ? HAT_UP_LEFT :
                      (y_next == AXIS_ZERO) ? HAT_LEFT : HAT_DOWN_LEFT;
            end
            else if (x_next == AXIS_ZERO)
            begin
                hat = (y_next == AXIS_NEG) ? HAT_UP :
                      (y_next == AXIS_ZERO) ? HAT_CENTER : HAT_DOWN;
            end
            else
            begin
                hat = (y_next == AXIS_NEG) ? HAT_UP_RIGHT :
                      (y_next == AXIS_ZERO) ? HAT_RIGHT : HAT_DOWN_RIGHT;
            end
        end
        misc_next[7:4] = hat;

        out_item.buttons  = btn_next;
        out_item.misc     = misc_next;
        out_item.x        = x_next;
        out_item.y        = y_next;
        out_item.send     = (cmd.chg != '0) && (cmd.mode == MODE_SEND);
        out_item.mode     = cmd.mode;
        out_item.mode_adv = cmd.mode_adv;
        out_item.led      = cmd.led;
    end

    // Stored report, advanced once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btn_reg  <= '0;
            misc_reg <= MISC_RESET;
            x_reg    <= AXIS_ZERO;
            y_reg    <= AXIS_ZERO;
        end
        else if (cmd_pop)
        begin
            btn_reg  <= btn_next;
            misc_reg <= misc_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
        end
    end

    // Output queue control.
    assign out_count_next = out_count_reg + {1'b0, cmd_pop} - {1'b0, out_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (cmd_pop)
            begin
                out_wr_ptr_reg <= ~out_wr_ptr_reg;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= ~out_rd_ptr_reg;
            end
            out_count_reg <= out_count_next;
        end
    end

    // Output queue storage.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_mem[out_wr_ptr_reg] <= out_item;
        end
    end

endmodule

/* sv/button_pad_to_hid_report.sv */
// ----------------------------------------------------------------------------
// button_pad_to_hid_report
// Turns 21 active-low button pin samples into a 4-byte gamepad report with
// turbo, guide-button turbo toggles and a long-hold mode selector.
// ----------------------------------------------------------------------------
// Flow: an accepted sample goes into the request queue, the report builder
//   moves its result into the output queue, and it is then on the result ports.
// Throughput: one sample per cycle, sustained while pop keeps up; the
//   two-entry request queue and two-entry output queue absorb stalls.
// Reset: asynchronous, active low; the report reads 00 f0 00 00, mode 0,
//   LED 0 lit, hold threshold 1000, both queues empty.
// ----------------------------------------------------------------------------
module button_pad_to_hid_report
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [bphr_pkg::PIN_W-1:0] raw_pins,
    output logic                       empty,
    input  logic                       pop,
    output logic [7:0]                 report_buttons,
    output logic [7:0]                 report_misc,
    output logic signed [7:0]          report_x,
    output logic signed [7:0]          report_y,
    output logic                       report_send,
    output logic [1:0]                 cur_mode_out,
    output logic                       mode_advanced,
    output logic [3:0]                 led_bits,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [11:0]                cfg_data
);
    import bphr_pkg::*;

    logic    accept;
    cmd_t    front_cmd;
    cmd_t    queue_cmd;
    logic    queue_empty;
    logic    queue_pop;
    result_t res;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    // Edge, turbo and guide handling.
    bphr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .raw_pins  (raw_pins),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (front_cmd)
    );

    // Request queue between front end and report builder.
    bphr_cmd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (queue_pop),
        .empty   (queue_empty),
        .rd_data (queue_cmd)
    );

    // Report builder and output queue.
    bphr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (queue_empty),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    // Result fields.
    assign report_buttons = res.buttons;
    assign report_misc    = res.misc;
    assign report_x       = res.x;
    assign report_y       = res.y;
    assign report_send    = res.send;
    assign cur_mode_out   = res.mode;
    assign mode_advanced  = res.mode_adv;
    assign led_bits       = res.led;

endmodule
